// ===== hdl/plpt_pkg.sv =====
package plpt_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned LEN_W   = 26;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned VEL_W   = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SEG_W   = 6;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned SQ_W    = 50;
  localparam int unsigned NUM_W   = 53;

  localparam logic [VEL_W-1:0] VEL_RESET = 24'd13107;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

endpackage

// ===== hdl/polyline_position_at_time_core.sv =====
// Operations: clear, full append, short query and unused opcode go straight to the result;
// a first append only stores its vertex; later appends add a length (25-step square root).
// Query: walks the segments one by one, then interpolates (53-step divide) or takes the end.
// Throughput: one word at a time; busy stays high through the result cycle, so the next
// word is accepted only after the block has returned to idle. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the path and sets velocity to 51.2 (unsigned Q16.8).
module polyline_position_at_time_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [plpt_pkg::COORD_W-1:0]  vertex_x_i,
  input  logic [plpt_pkg::COORD_W-1:0]  vertex_y_i,
  input  logic [plpt_pkg::TIME_W-1:0]   time_ms_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plpt_pkg::VEL_W-1:0]    cfg_data_i,
  output logic                          result_valid_o,
  output logic [plpt_pkg::COORD_W-1:0]  pos_x_o,
  output logic [plpt_pkg::COORD_W-1:0]  pos_y_o,
  output logic [plpt_pkg::SEG_W-1:0]    segment_index_o,
  output logic                          reached_end_o,
  output logic [1:0]                    status_o
);
  import plpt_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_AP_D  = 5'd1;
  localparam logic [4:0] S_AP_MX = 5'd2;
  localparam logic [4:0] S_AP_MY = 5'd3;
  localparam logic [4:0] S_AP_SQ = 5'd4;
  localparam logic [4:0] S_AP_WR = 5'd5;
  localparam logic [4:0] S_Q_MUL = 5'd6;
  localparam logic [4:0] S_Q_CMP = 5'd7;
  localparam logic [4:0] S_W_RD  = 5'd8;
  localparam logic [4:0] S_W_CHK = 5'd9;
  localparam logic [4:0] S_L_RD0 = 5'd10;
  localparam logic [4:0] S_L_RD1 = 5'd11;
  localparam logic [4:0] S_L_PRE = 5'd12;
  localparam logic [4:0] S_L_MUL = 5'd13;
  localparam logic [4:0] S_L_NUM = 5'd14;
  localparam logic [4:0] S_L_DIV = 5'd15;
  localparam logic [4:0] S_E_RD  = 5'd16;
  localparam logic [4:0] S_E_CAP = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  logic [4:0]         state_q, state_d;
  logic [CW-1:0]      count_q;
  logic [TOTAL_W-1:0] total_q;
  logic [VEL_W-1:0]   vel_q;

  logic [COORD_W-1:0] x_mem [MAX_VERTICES];
  logic [COORD_W-1:0] y_mem [MAX_VERTICES];
  logic [LEN_W-1:0]   seg_mem [MAX_VERTICES-1];
  logic [COORD_W-1:0] x_rd_q, y_rd_q;
  logic [LEN_W-1:0]   seg_rd_q;
  logic [AW-1:0]      raddr;

  logic [COORD_W-1:0] vx_q, vy_q;
  logic [TIME_W-1:0]  time_q;
  logic signed [COORD_W:0] dx_q, dy_q;
  logic [SQ_W-1:0]    sq_q, res_q, bit_q;
  logic [47:0]        dist_q;
  logic [SUM_W-1:0]   sum_q;
  logic [AW-1:0]      idx_q;
  logic [LEN_W-1:0]   rest_q, len_q;
  logic [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic [COORD_W:0]   magx_q, magy_q;
  logic               negx_q, negy_q;
  logic [NUM_W-1:0]   numx_q, numy_q;
  logic [LEN_W:0]     remx_q, remy_q;
  logic [5:0]         div_cnt_q;

  logic [COORD_W-1:0] px_q, py_q;
  logic [AW-1:0]      seg_q;
  logic               end_q;
  logic [1:0]         st_q;

  logic [SQ_W-1:0]    sq_rb;
  logic               sq_ge;
  logic [SUM_W-1:0]   walk_sum;
  logic               walk_hit;
  logic               walk_last;
  logic [LEN_W+1:0]   remx_sh, remy_sh, den;
  logic               gex, gey;
  logic [TOTAL_W:0]   total_add;
  logic [COORD_W:0]   ex_b, ey_b, ex_q, ey_q;
  logic signed [COORD_W:0] lx_d, ly_d;
  logic [31:0]        seg_ext;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign sq_rb     = res_q + bit_q;
  assign sq_ge     = (sq_q >= sq_rb);
  assign walk_sum  = sum_q + SUM_W'(seg_rd_q);
  assign walk_hit  = (walk_sum > SUM_W'(dist_q));
  assign walk_last = ((CW'(idx_q) + CW'(2)) == count_q);
  assign den       = {1'b0, len_q, 1'b0};
  assign remx_sh   = {remx_q, numx_q[NUM_W-1]};
  assign remy_sh   = {remy_q, numy_q[NUM_W-1]};
  assign gex       = (remx_sh >= den);
  assign gey       = (remy_sh >= den);
  assign total_add = {1'b0, total_q} + (TOTAL_W+1)'(res_q[LEN_W-1:0]);
  assign lx_d      = $signed({ax_q[COORD_W-1], ax_q}) - $signed({x_rd_q[COORD_W-1], x_rd_q});
  assign ly_d      = $signed({ay_q[COORD_W-1], ay_q}) - $signed({y_rd_q[COORD_W-1], y_rd_q});
  assign ex_b      = {bx_q[COORD_W-1], bx_q};
  assign ey_b      = {by_q[COORD_W-1], by_q};
  assign ex_q      = negx_q ? ex_b - {numx_q[COORD_W-1:0], gex}
                            : ex_b + {numx_q[COORD_W-1:0], gex};
  assign ey_q      = negy_q ? ey_b - {numy_q[COORD_W-1:0], gey}
                            : ey_b + {numy_q[COORD_W-1:0], gey};

  always_comb begin
    raddr = idx_q;
    unique case (state_q)
      S_IDLE:          raddr = AW'(count_q - CW'(1));
      S_L_RD1:         raddr = idx_q + AW'(1);
      S_E_RD:          raddr = AW'(count_q - CW'(1));
      default:         raddr = idx_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_i)
            OP_APPEND: begin
              if (count_q >= CW'(MAX_VERTICES)) state_d = S_DONE;
              else if (count_q == '0)           state_d = S_AP_WR;
              else                              state_d = S_AP_D;
            end
            OP_QUERY: state_d = (count_q < CW'(2)) ? S_DONE : S_Q_MUL;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_AP_D:  state_d = S_AP_MX;
      S_AP_MX: state_d = S_AP_MY;
      S_AP_MY: state_d = S_AP_SQ;
      S_AP_SQ: if (bit_q[0]) state_d = S_AP_WR;
      S_AP_WR: state_d = S_DONE;
      S_Q_MUL: state_d = S_Q_CMP;
      S_Q_CMP: state_d = (dist_q < 48'(total_q)) ? S_W_RD : S_E_RD;
      S_W_RD:  state_d = S_W_CHK;
      S_W_CHK: begin
        priority if (walk_hit) state_d = S_L_RD0;
        else if (walk_last)    state_d = S_E_RD;
        else                   state_d = S_W_RD;
      end
      S_L_RD0: state_d = S_L_RD1;
      S_L_RD1: state_d = S_L_PRE;
      S_L_PRE: state_d = S_L_MUL;
      S_L_MUL: state_d = S_L_NUM;
      S_L_NUM: state_d = S_L_DIV;
      S_L_DIV: if (div_cnt_q == '0) state_d = S_DONE;
      S_E_RD:  state_d = S_E_CAP;
      S_E_CAP: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      total_q <= '0;
      vel_q   <= VEL_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) vel_q <= cfg_data_i;
      if (state_q == S_IDLE && start && opcode_i == OP_CLEAR) begin
        count_q <= '0;
        total_q <= '0;
      end
      if (state_q == S_AP_WR) begin
        count_q <= count_q + CW'(1);
        if (count_q != '0) total_q <= total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_AP_WR) begin
      x_mem[AW'(count_q)] <= vx_q;
      y_mem[AW'(count_q)] <= vy_q;
      if (count_q != '0) seg_mem[AW'(count_q - CW'(1))] <= res_q[LEN_W-1:0];
    end
    x_rd_q   <= x_mem[raddr];
    y_rd_q   <= y_mem[raddr];
    seg_rd_q <= seg_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        vx_q   <= vertex_x_i;
        vy_q   <= vertex_y_i;
        time_q <= time_ms_i;
        px_q   <= '0;
        py_q   <= '0;
        seg_q  <= '0;
        end_q  <= 1'b0;
        res_q  <= '0;
        st_q   <= ST_OK;
        if (opcode_i == OP_APPEND && count_q >= CW'(MAX_VERTICES)) st_q <= ST_FULL;
        if (opcode_i == OP_QUERY && count_q < CW'(2))              st_q <= ST_SHORT;
      end
      S_AP_D: begin
        dx_q <= $signed({vx_q[COORD_W-1], vx_q}) - $signed({x_rd_q[COORD_W-1], x_rd_q});
        dy_q <= $signed({vy_q[COORD_W-1], vy_q}) - $signed({y_rd_q[COORD_W-1], y_rd_q});
      end
      S_AP_MX: sq_q <= SQ_W'(dx_q * dx_q);
      S_AP_MY: begin
        sq_q  <= sq_q + SQ_W'(dy_q * dy_q);
        res_q <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      S_AP_SQ: begin
        if (sq_ge) begin
          sq_q  <= sq_q - sq_rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_Q_MUL: dist_q <= 48'((56'(time_q) * 56'(vel_q)) >> 8);
      S_Q_CMP: begin
        idx_q <= '0;
        sum_q <= '0;
      end
      S_W_CHK: begin
        if (walk_hit) begin
          rest_q <= LEN_W'(walk_sum - SUM_W'(dist_q));
          len_q  <= seg_rd_q;
        end else begin
          sum_q <= walk_sum;
          if (!walk_last) idx_q <= idx_q + AW'(1);
        end
      end
      S_L_RD1: begin
        ax_q <= x_rd_q;
        ay_q <= y_rd_q;
      end
      S_L_PRE: begin
        bx_q   <= x_rd_q;
        by_q   <= y_rd_q;
        negx_q <= lx_d[COORD_W];
        negy_q <= ly_d[COORD_W];
        magx_q <= lx_d[COORD_W] ? 25'(-lx_d) : 25'(lx_d);
        magy_q <= ly_d[COORD_W] ? 25'(-ly_d) : 25'(ly_d);
      end
      S_L_MUL: begin
        numx_q <= NUM_W'(51'(magx_q) * 51'(rest_q));
        numy_q <= NUM_W'(51'(magy_q) * 51'(rest_q));
      end
      S_L_NUM: begin
        numx_q    <= {numx_q[NUM_W-2:0], 1'b0} + NUM_W'(len_q);
        numy_q    <= {numy_q[NUM_W-2:0], 1'b0} + NUM_W'(len_q);
        remx_q    <= '0;
        remy_q    <= '0;
        div_cnt_q <= 6'(NUM_W - 1);
      end
      S_L_DIV: begin
        remx_q    <= gex ? (LEN_W+1)'(remx_sh - den) : remx_sh[LEN_W:0];
        remy_q    <= gey ? (LEN_W+1)'(remy_sh - den) : remy_sh[LEN_W:0];
        numx_q    <= {numx_q[NUM_W-2:0], gex};
        numy_q    <= {numy_q[NUM_W-2:0], gey};
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == '0) begin
          px_q  <= ex_q[COORD_W-1:0];
          py_q  <= ey_q[COORD_W-1:0];
          seg_q <= idx_q;
        end
      end
      S_E_CAP: begin
        px_q  <= x_rd_q;
        py_q  <= y_rd_q;
        seg_q <= AW'(count_q - CW'(2));
        end_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign seg_ext         = 32'(seg_q);
  assign result_valid_o  = (state_q == S_DONE);
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign segment_index_o = seg_ext[SEG_W-1:0];
  assign reached_end_o   = end_q;
  assign status_o        = st_q;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy) else $error("busy after result");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES)) else $error("vertex count overflow");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plpt_pkg::*;

  localparam int unsigned MAXV = 64;
  localparam int unsigned LIMIT = 4000000;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [SEG_W-1:0]   seg;
    logic               at_end;
    logic [1:0]         status;
  } position_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = OP_CLEAR;
  logic [COORD_W-1:0] vertex_x_i = '0;
  logic [COORD_W-1:0] vertex_y_i = '0;
  logic [TIME_W-1:0] time_ms_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [VEL_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [COORD_W-1:0] pos_x_o, pos_y_o;
  logic [SEG_W-1:0] segment_index_o;
  logic reached_end_o;
  logic [1:0] status_o;

  polyline_position_at_time_core #(.MAX_VERTICES(MAXV)) i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // path mirror
  longint path_x[MAXV];
  longint path_y[MAXV];
  longint seg_len[MAXV];
  int unsigned n_points;
  longint unsigned path_total;
  logic [VEL_W-1:0] speed;

  position_t pending_pos[$];
  int errors = 0;
  longint unsigned cycles = 0;
  int burst_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint blend(longint a, longint b, longint unsigned rest,
                                   longint unsigned len);
    longint d;
    longint unsigned mag, q;
    d = a - b;
    mag = (d < 0) ? -d : d;
    q = (mag * rest * 2 + len) / (len * 2);
    return (d < 0) ? b - longint'(q) : b + longint'(q);
  endfunction

  function automatic position_t predict_position(logic [1:0] op, logic [COORD_W-1:0] vx,
                                                 logic [COORD_W-1:0] vy,
                                                 logic [TIME_W-1:0] tm);
    position_t r;
    longint x, y, dx, dy;
    longint unsigned len, travel, sum;
    bit found;
    r = '0;
    r.status = ST_OK;
    if (op == OP_CLEAR) begin
      n_points = 0;
      path_total = 0;
    end else if (op == OP_APPEND) begin
      if (n_points >= MAXV) begin
        r.status = ST_FULL;
      end else begin
        x = longint'(signed'(vx));
        y = longint'(signed'(vy));
        if (n_points > 0) begin
          dx = x - path_x[n_points-1];
          dy = y - path_y[n_points-1];
          len = int_sqrt(dx*dx + dy*dy);
          seg_len[n_points-1] = len;
          path_total += len;
          if (path_total > 64'hFFFF_FFFF) path_total = 64'hFFFF_FFFF;
        end
        path_x[n_points] = x;
        path_y[n_points] = y;
        n_points++;
      end
    end else if (op == OP_QUERY) begin
      if (n_points < 2) begin
        r.status = ST_SHORT;
      end else begin
        travel = (longint'(tm) * longint'(speed)) >> 8;
        found = 0;
        sum = 0;
        if (travel < path_total) begin
          for (int i = 0; i < n_points - 1 && !found; i++) begin
            sum += seg_len[i];
            if (sum > travel) begin
              r.pos_x = COORD_W'(blend(path_x[i], path_x[i+1], sum - travel, seg_len[i]));
              r.pos_y = COORD_W'(blend(path_y[i], path_y[i+1], sum - travel, seg_len[i]));
              r.seg = SEG_W'(i);
              found = 1;
            end
          end
        end
        if (!found) begin
          r.pos_x = COORD_W'(path_x[n_points-1]);
          r.pos_y = COORD_W'(path_y[n_points-1]);
          r.seg = SEG_W'(n_points - 2);
          r.at_end = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("polyline_position_at_time_core test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    position_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_pos.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_pos.pop_front();
        if (pos_x_o !== want.pos_x) begin
          $error("pos_x expected %h got %h", want.pos_x, pos_x_o); errors++;
        end
        if (pos_y_o !== want.pos_y) begin
          $error("pos_y expected %h got %h", want.pos_y, pos_y_o); errors++;
        end
        if (segment_index_o !== want.seg) begin
          $error("segment_index expected %0d got %0d", want.seg, segment_index_o); errors++;
        end
        if (reached_end_o !== want.at_end) begin
          $error("reached_end expected %b got %b", want.at_end, reached_end_o); errors++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0d got %0d", want.status, status_o); errors++;
        end
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [COORD_W-1:0] vx = '0,
                           logic [COORD_W-1:0] vy = '0, logic [TIME_W-1:0] tm = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    start <= 1'b1;
    opcode_i <= op;
    vertex_x_i <= vx;
    vertex_y_i <= vy;
    time_ms_i <= tm;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_pos = {pending_pos, predict_position(op, vx, vy, tm)};
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_speed(logic [VEL_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    speed = v;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int unsigned spread);
    case (spread)
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return COORD_W'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_QUERY, '0, '0, 32'd5);
    send_word(OP_APPEND, 24'h000100, 24'h000100);
    send_word(OP_QUERY, '0, '0, 32'd0);
    send_word(OP_APPEND, 24'h000500, 24'h000400);
    send_word(OP_APPEND, 24'h7FFFFF, 24'h800000);
    send_word(OP_APPEND, 24'h800000, 24'h7FFFFF);
    send_word(OP_QUERY, '0, '0, 32'd0);
    send_word(OP_QUERY, '0, '0, 32'd1);
    send_word(OP_QUERY, '0, '0, 32'd6000);
    send_word(OP_QUERY, '0, '0, 32'hFFFFFFFF);
    send_word(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_word(OP_CLEAR);
    send_word(OP_APPEND, 24'h000000, 24'h000000);
    send_word(OP_APPEND, 24'h000000, 24'h000000);
    send_word(OP_APPEND, 24'h000A00, 24'h000000);
    send_word(OP_QUERY, '0, '0, 32'd0);
    send_word(OP_QUERY, '0, '0, 32'd50);
    // well past the end of the 2560-unit path at the reset velocity of 51.2 units per ms
    send_word(OP_QUERY, '0, '0, 32'd12800);
    send_word(OP_QUERY, '0, '0, 32'd12799);
  endtask

  task automatic test_full_path();
    send_word(OP_CLEAR);
    for (int i = 0; i < MAXV + 2; i++)
      send_word(OP_APPEND, rand_coord(1), rand_coord(1));
    send_word(OP_QUERY, '0, '0, $urandom_range(0, 3000));
    send_word(OP_QUERY, '0, '0, 32'hFFFFFFFF);
  endtask

  task automatic test_random_paths(int unsigned n_words);
    int unsigned sent, pts, spread;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom), $urandom);
        sent++;
        continue;
      end
      send_word(OP_CLEAR);
      pts = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
      spread = $urandom_range(0, 2);
      for (int i = 0; i < pts; i++) send_word(OP_APPEND, rand_coord(spread), rand_coord(spread));
      for (int i = 0; i < $urandom_range(2, 8); i++) begin
        if ($urandom_range(0, 5) == 0)
          send_word(OP_QUERY, '0, '0, $urandom);
        else
          send_word(OP_QUERY, '0, '0,
                    TIME_W'((path_total * 256) / (speed == 0 ? 1 : speed) *
                            $urandom_range(0, 110) / 100));
      end
      sent += pts + 6;
    end
  endtask

  initial begin
    n_points = 0;
    path_total = 0;
    speed = VEL_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_path();
    // hold until the path is quiet
    drain();
    test_random_paths(300);
    set_speed(24'hFFFFFF);
    test_random_paths(250);
    set_speed(24'd0);
    test_random_paths(150);
    set_speed(24'd1);
    test_random_paths(200);
    set_speed(VEL_W'($urandom));
    test_random_paths(300);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("polyline_position_at_time_core test passed");
    end else begin
      $display("polyline_position_at_time_core test failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/plpt_pkg.sv
hdl/polyline_position_at_time_core.sv
test/tb.sv
